>>> src/ppid_pkg.sv
// ppid_pkg: shared widths, constants and types for the positional PID block.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package ppid_pkg;

    localparam int GAIN_W    = 32;   // signed Q16.16 gains
    localparam int CAP_W     = 16;   // integral cap, dead zone, error cutoff
    localparam int OCAP_W    = 15;   // output cap
    localparam int DRIVE_W   = 16;   // result word
    localparam int PROD_W    = 63;   // saturated product, +/-2^61 fits
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic signed [63:0] PROD_LIMIT = 64'sd2305843009213693952; // 2^61

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_INTEGRAL_CAP = 3'd3,
        REG_OUTPUT_CAP   = 3'd4,
        REG_DEAD_ZONE    = 3'd5,
        REG_ERROR_CUTOFF = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [CAP_W-1:0]         integral_cap;
        logic [OCAP_W-1:0]        output_cap;
        logic [CAP_W-1:0]         dead_zone;
        logic [CAP_W-1:0]         error_cutoff;
    } pid_cfg_t;

endpackage

>>> src/positional_pid_with_deadband_top.sv
// positional_pid_with_deadband_top: stream wrapper, register file and
// result register around ppid_core. Depends on ppid_pkg, ppid_core.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one word per control
//   sample: measured in the low SAMPLE_WIDTH bits, target above it.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one word per sample:
//   the signed drive value.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   gain_p, gain_i, gain_d, integral_cap, output_cap, dead_zone and
//   error_cutoff at indices 0..6; other indices are dropped. cfg_ready is
//   always high. Write only while no sample is in flight.
//   Path: a sample passes the input register, then the single-pass PID
//   datapath into the result register, which raises m_tvalid.
//   Throughput: one word per cycle while m_tready stays high; the integral
//   and last error update at the same edge the result is captured, so
//   samples may arrive back to back.
//   Reset (rst_n low, asynchronous) clears the register file, the integral,
//   the last error and both valid flags.
//   When the receiver stalls, the result register holds its word and the
//   input register may still fill, so one further word is taken before
//   s_tready drops.

module positional_pid_with_deadband_top #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppid_pkg::CFG_DAT_W-1:0]    cfg_data,
    // sample stream in: measured, target, zero pad to whole bytes
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // drive stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppid_pkg::DRIVE_W-1:0]      m_tdata    // drive
);
    ppid_pkg::pid_cfg_t cfg_reg;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] measured_reg;
    logic signed [SAMPLE_WIDTH-1:0] target_reg;

    logic                                out_valid_reg;
    logic signed [ppid_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [ppid_pkg::DRIVE_W-1:0] drive_next;

    logic advance;   // input register moves into the result register
    logic s_take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_take    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = drive_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (ppid_pkg::cfg_index_t'(cfg_index))
                ppid_pkg::REG_GAIN_P:       cfg_reg.gain_p       <= cfg_data;
                ppid_pkg::REG_GAIN_I:       cfg_reg.gain_i       <= cfg_data;
                ppid_pkg::REG_GAIN_D:       cfg_reg.gain_d       <= cfg_data;
                ppid_pkg::REG_INTEGRAL_CAP: cfg_reg.integral_cap <= cfg_data[ppid_pkg::CAP_W-1:0];
                ppid_pkg::REG_OUTPUT_CAP:   cfg_reg.output_cap   <= cfg_data[ppid_pkg::OCAP_W-1:0];
                ppid_pkg::REG_DEAD_ZONE:    cfg_reg.dead_zone    <= cfg_data[ppid_pkg::CAP_W-1:0];
                ppid_pkg::REG_ERROR_CUTOFF: cfg_reg.error_cutoff <= cfg_data[ppid_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            measured_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            target_reg   <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
    end

    ppid_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .measured (measured_reg),
        .target   (target_reg),
        .cfg      (cfg_reg),
        .drive    (drive_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            drive_reg <= drive_next;
    end

endmodule

>>> src/ppid_mul_sat.sv
// ppid_mul_sat: signed gain times operand, saturated to +/-2^61.
// Depends on ppid_pkg.
`timescale 1ns / 1ps

module ppid_mul_sat #(
    parameter int OPW = 17
) (
    input  logic signed [ppid_pkg::GAIN_W-1:0] a,
    input  logic signed [OPW-1:0]              b,
    output logic signed [ppid_pkg::PROD_W-1:0] y
);
    localparam int PW = ppid_pkg::GAIN_W + OPW;
    localparam int XW = (PW > ppid_pkg::PROD_W) ? PW : ppid_pkg::PROD_W;

    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] prod_x;
    logic signed [XW-1:0] lim;

    always_comb
    begin
        prod   = PW'(a) * PW'(b);
        prod_x = XW'(prod);
        lim    = XW'(ppid_pkg::PROD_LIMIT);
        if (prod_x > lim)
            y = ppid_pkg::PROD_W'(lim);
        else if (prod_x < -lim)
            y = ppid_pkg::PROD_W'(-lim);
        else
            y = ppid_pkg::PROD_W'(prod_x);
    end

endmodule

>>> src/ppid_core.sv
// ppid_core: error gating, P/I/D terms, clamps, and the integral and
// last-error state. Depends on ppid_pkg and ppid_mul_sat.
`timescale 1ns / 1ps

module ppid_core #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic signed [SAMPLE_WIDTH-1:0]      measured,
    input  logic signed [SAMPLE_WIDTH-1:0]      target,
    input  ppid_pkg::pid_cfg_t                  cfg,
    output logic signed [ppid_pkg::DRIVE_W-1:0] drive
);
    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int DW   = EW + 1;
    localparam int CW   = (EW > ppid_pkg::CAP_W) ? EW : ppid_pkg::CAP_W;
    localparam int IAW  = ppid_pkg::CAP_W + GAIN_FRAC_BITS + 2;
    localparam int ISW  = ppid_pkg::PROD_W + 1;
    localparam int SUMW = ppid_pkg::PROD_W + 2;

    logic signed [IAW-1:0] integral_reg;
    logic signed [IAW-1:0] integral_next;
    logic signed [EW-1:0]  prev_err_reg;

    logic signed [EW-1:0]  err;
    logic [CW-1:0]         err_mag;
    logic signed [DW-1:0]  err_diff;
    logic                  gated;

    logic signed [ppid_pkg::PROD_W-1:0] p_term;
    logic signed [ppid_pkg::PROD_W-1:0] i_step;
    logic signed [ppid_pkg::PROD_W-1:0] d_term;

    logic signed [ISW-1:0]  isum;
    logic signed [ISW-1:0]  icap;
    logic signed [SUMW-1:0] total;
    logic signed [SUMW-1:0] shifted;
    logic signed [SUMW-1:0] ocap;

    always_comb
    begin
        err      = EW'(target) - EW'(measured);
        err_mag  = err[EW-1] ? CW'(-err) : CW'(err);
        err_diff = DW'(err) - DW'(prev_err_reg);
        gated    = ((cfg.error_cutoff != '0) && (err_mag > CW'(cfg.error_cutoff))) ||
                   ((cfg.dead_zone != '0) && (err_mag < CW'(cfg.dead_zone)));
    end

    ppid_mul_sat #(.OPW(EW)) u_mul_p (.a(cfg.gain_p), .b(err),      .y(p_term));
    ppid_mul_sat #(.OPW(EW)) u_mul_i (.a(cfg.gain_i), .b(err),      .y(i_step));
    ppid_mul_sat #(.OPW(DW)) u_mul_d (.a(cfg.gain_d), .b(err_diff), .y(d_term));

    always_comb
    begin
        // integral clamp to +/- (cap << frac)
        icap = $signed({{(ISW - ppid_pkg::CAP_W){1'b0}}, cfg.integral_cap}) <<< GAIN_FRAC_BITS;
        isum = ISW'(integral_reg) + ISW'(i_step);
        if (isum > icap)
            integral_next = IAW'(icap);
        else if (isum < -icap)
            integral_next = IAW'(-icap);
        else
            integral_next = IAW'(isum);

        total   = SUMW'(p_term) + SUMW'(integral_next) + SUMW'(d_term);
        shifted = total >>> GAIN_FRAC_BITS;
        ocap    = $signed({{(SUMW - ppid_pkg::OCAP_W){1'b0}}, cfg.output_cap});
        if (gated)
            drive = '0;
        else if (shifted > ocap)
            drive = ppid_pkg::DRIVE_W'(ocap);
        else if (shifted < -ocap)
            drive = ppid_pkg::DRIVE_W'(-ocap);
        else
            drive = ppid_pkg::DRIVE_W'(shifted);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (fire && !gated)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= err;
        end
    end

endmodule

>>> verif/pid_drive_checker.sv
// pid_drive_checker: watches the config, sample and drive channels, predicts
// every drive word and compares it with the block's output. Uses ppid_pkg.
`timescale 1ns / 1ps

module pid_drive_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // measured, target
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ppid_pkg::DRIVE_W-1:0]       m_tdata,   // drive
    output int                                 due_count,
    output int                                 fail_count
);
    localparam int FRAC = 16;

    ppid_pkg::pid_cfg_t                  regs;
    longint                              integ;     // Q16.16
    longint                              last_err;
    int                                  fails;
    logic signed [ppid_pkg::DRIVE_W-1:0] drive_due [$];
    logic signed [ppid_pkg::DRIVE_W-1:0] want;

    function automatic longint clamp_mag(longint v, longint cap);
        if (v > cap)
            return cap;
        if (v < -cap)
            return -cap;
        return v;
    endfunction

    // One control step; updates integral and last error unless gated off.
    function automatic logic signed [ppid_pkg::DRIVE_W-1:0] next_drive(
        logic signed [15:0] meas, logic signed [15:0] targ);
        longint e;
        longint ae;
        longint sum;
        longint res;
        e  = longint'(targ) - longint'(meas);
        ae = (e < 0) ? -e : e;
        if ((regs.error_cutoff != 0 && ae > longint'(regs.error_cutoff)) ||
            (regs.dead_zone != 0 && ae < longint'(regs.dead_zone)))
            return '0;
        integ = clamp_mag(integ + longint'($signed(regs.gain_i)) * e,
                          longint'(regs.integral_cap) <<< FRAC);
        sum = longint'($signed(regs.gain_p)) * e + integ
            + longint'($signed(regs.gain_d)) * (e - last_err);
        last_err = e;
        res = clamp_mag(sum >>> FRAC, longint'(regs.output_cap));
        return res[ppid_pkg::DRIVE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs     = '0;
            integ    = 0;
            last_err = 0;
            fails    = 0;
            drive_due.delete();
            due_count  <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ppid_pkg::REG_GAIN_P:       regs.gain_p       = cfg_data;
                    ppid_pkg::REG_GAIN_I:       regs.gain_i       = cfg_data;
                    ppid_pkg::REG_GAIN_D:       regs.gain_d       = cfg_data;
                    ppid_pkg::REG_INTEGRAL_CAP:
                        regs.integral_cap = cfg_data[ppid_pkg::CAP_W-1:0];
                    ppid_pkg::REG_OUTPUT_CAP:
                        regs.output_cap   = cfg_data[ppid_pkg::OCAP_W-1:0];
                    ppid_pkg::REG_DEAD_ZONE:
                        regs.dead_zone    = cfg_data[ppid_pkg::CAP_W-1:0];
                    ppid_pkg::REG_ERROR_CUTOFF:
                        regs.error_cutoff = cfg_data[ppid_pkg::CAP_W-1:0];
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_due.push_back(next_drive(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                if (drive_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: drive %0d arrived with nothing expected",
                             $time, $signed(m_tdata));
                end
                else
                begin
                    want = drive_due.pop_front();
                    if (m_tdata !== want)
                    begin
                        fails++;
                        $display("%0t: drive mismatch, expected %0d, got %0d",
                                 $time, want, $signed(m_tdata));
                    end
                end
            end
            due_count  <= drive_due.size();
            fail_count <= fails;
        end
    end

endmodule

>>> verif/tb_positional_pid_with_deadband_top.sv
// tb_positional_pid_with_deadband_top: stimulus and verdict for the PID block.
// Depends on ppid_pkg, positional_pid_with_deadband_top and pid_drive_checker.
`timescale 1ns / 1ps

module tb_positional_pid_with_deadband_top;

    localparam int HALF           = 4;      // 8 ns clock
    localparam int IN_W           = 32;     // measured + target, no padding
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no word moved
    localparam int TAIL           = 8;      // idle clocks after the final drain
    localparam int BLOCKS         = 8;
    localparam int BLOCK_LEN      = 75;
    // Index 7 has no register behind it; the write must be dropped.
    localparam logic [ppid_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ppid_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ppid_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [IN_W-1:0]                s_tdata;   // measured [15:0], target [31:16]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ppid_pkg::DRIVE_W-1:0]   m_tdata;   // drive [15:0]

    int due_count;
    int fail_count;
    int src_idle;      // percent of cycles the sender holds back
    int sink_stall;    // percent of cycles the receiver refuses a word
    int quiet;
    int samples;
    int settings;
    int cur_dz;        // copies of the gating limits, used to aim errors at them
    int cur_cut;

    always #(HALF) clk = ~clk;

    positional_pid_with_deadband_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pid_drive_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .due_count  (due_count),
        .fail_count (fail_count)
    );

    // Receiver: a fresh coin each cycle, weighted by the current stall rate.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall);

    // Watchdog: any accepted word on any channel resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one sample word. Valid is only dropped while idling, so a
    // back-to-back word never sees valid fall and rise in one step.
    task automatic push_sample(input int meas, input int targ);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(targ), 16'(meas)};
        do
            @(posedge clk);
        while (!s_tready);
        samples++;
    endtask

    // Hold the sender off until every expected drive word has come back.
    // The count from the checker is registered, hence the first wait.
    task automatic drain_drives();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    task automatic cfg_put(input logic [ppid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Full register set, written only once the block is idle.
    task automatic load_settings(input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input int icap,
                                 input int ocap, input int dz, input int cut);
        drain_drives();
        cfg_put(ppid_pkg::REG_GAIN_P, gp);
        cfg_put(ppid_pkg::REG_GAIN_I, gi);
        cfg_put(ppid_pkg::REG_GAIN_D, gd);
        cfg_put(ppid_pkg::REG_INTEGRAL_CAP, icap);
        cfg_put(ppid_pkg::REG_OUTPUT_CAP, ocap);
        cfg_put(ppid_pkg::REG_DEAD_ZONE, dz);
        cfg_put(ppid_pkg::REG_ERROR_CUTOFF, cut);
        cfg_valid <= 1'b0;
        cur_dz  = dz;
        cur_cut = cut;
        settings++;
    endtask

    function automatic logic [31:0] rand_gain();
        int g;
        case ($urandom_range(7))
            0:       g = 32'h7FFF_FFFF;
            1:       g = 32'h8000_0000;
            2:       g = $urandom;
            default:
            begin
                g = $urandom_range(0, 4 << 16);   // up to 4.0 in Q16.16
                if ($urandom_range(1))
                    g = -g;
            end
        endcase
        return g;
    endfunction

    function automatic int rand_cap(input int top);
        case ($urandom_range(7))
            0:       return 0;
            1:       return top;
            2:       return $urandom_range(0, top);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Sample mix: mostly small errors around a random operating point, some
    // full-range noise, rails, zero error, and errors aimed at the gates.
    task automatic push_random();
        int m;
        int t;
        int e;
        m = $signed(16'($urandom));
        case ($urandom_range(9))
            0, 1:    t = $signed(16'($urandom));
            7:
            begin
                e = ($urandom_range(1) ? cur_dz : cur_cut) + $urandom_range(2) - 1;
                if ($urandom_range(1))
                    e = -e;
                m = $urandom_range(0, 2000) - 1000;
                t = sat16(m + e);
            end
            8:
            begin
                m = $urandom_range(1) ? -32768 : 32767;
                t = $urandom_range(1) ? -32768 : 32767;
            end
            9:       t = m;
            default: t = sat16(m + $urandom_range(0, 600) - 300);
        endcase
        push_sample(m, t);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        src_idle   = 0;
        sink_stall = 0;
        quiet      = 0;
        samples    = 0;
        settings   = 0;
        cur_dz     = 0;
        cur_cut    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: plain gains, rails and zero error
        load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 100, 1000, 0, 0);
        push_sample(0, 0);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        push_sample(100, 100);
        push_sample(0, 10);
        push_sample(0, -10);

        // largest gains and caps: output and integral clamps at the top end
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535, 32767, 0, 0);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        push_sample(-1, 0);

        // most negative gains with zero caps: drive and integral pinned at 0
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);

        // dead zone of 5 and cutoff of 1000: both edges of each gate
        load_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 500, 32767, 5, 1000);
        push_sample(0, 4);
        push_sample(0, -4);
        push_sample(0, 5);
        push_sample(10, 5);
        push_sample(0, 1000);
        push_sample(0, 1001);
        push_sample(0, -1001);
        push_sample(1000, 0);

        // a write to an unused index must leave the settings alone
        drain_drives();
        cfg_put(REG_SPARE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        push_sample(3, 7);
        push_sample(-20, 20);

        // --- random: one register set per block, flow-control mix rotates
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            case (blk % 4)
                0:
                begin
                    src_idle   = 0;
                    sink_stall = 0;
                end
                1:
                begin
                    src_idle   = 47;
                    sink_stall = 0;
                end
                2:
                begin
                    src_idle   = 0;
                    sink_stall = 47;
                end
                default:
                begin
                    src_idle   = 30;
                    sink_stall = 30;
                end
            endcase
            if (blk == 2)
                load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              65535, 32767, 0, 0);
            else if (blk == 5)
                load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              $urandom_range(1, 2000), $urandom_range(1, 32767), 0, 0);
            else
                load_settings(rand_gain(), rand_gain(), rand_gain(),
                              rand_cap(65535), rand_cap(32767),
                              $urandom_range(1) ? 0 : $urandom_range(1, 200),
                              $urandom_range(1) ? 0 : $urandom_range(200, 65535));
            for (int k = 0; k < BLOCK_LEN; k++)
            begin
                // mid-block, let the pipeline run dry before carrying on
                if (k == BLOCK_LEN / 2)
                    drain_drives();
                push_random();
            end
        end

        drain_drives();
        repeat (TAIL) @(posedge clk);

        $display("Covered %0d samples over %0d register sets, with idle and stalled",
                 samples, settings);
        $display("phases on both streams, rails, gate edges and clamp extremes.");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
